// ----- design/binary_to_roman_numeral_encoder_top_defines.svh -----
// ----------------------------------------------------------------------------
// Roman numeral encoder: assertion macros
// Shorthands for the concurrent checks in the encoder's datapath.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_ROMAN_NUMERAL_ENCODER_TOP_DEFINES_SVH
`define BINARY_TO_ROMAN_NUMERAL_ENCODER_TOP_DEFINES_SVH

// Checked on every rising clock edge while reset is released.
`define B2R_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define B2R_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/b2r_pkg.sv -----
// ----------------------------------------------------------------------------
// Roman numeral encoder package
// Types, symbol codes and the numeral weight table shared by the encoder.
// ----------------------------------------------------------------------------
package b2r_pkg;

  localparam int unsigned VALUE_W   = 12;
  localparam int unsigned SYMBOL_W  = 8;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

  localparam int unsigned TBL_N     = 13;
  localparam int unsigned TBL_IDX_W = $clog2(TBL_N);

  localparam logic [SYMBOL_W-1:0] CH_M = 8'h4D;
  localparam logic [SYMBOL_W-1:0] CH_D = 8'h44;
  localparam logic [SYMBOL_W-1:0] CH_C = 8'h43;
  localparam logic [SYMBOL_W-1:0] CH_L = 8'h4C;
  localparam logic [SYMBOL_W-1:0] CH_X = 8'h58;
  localparam logic [SYMBOL_W-1:0] CH_V = 8'h56;
  localparam logic [SYMBOL_W-1:0] CH_I = 8'h49;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero;
    logic final_char;
  } sts_t;

  // One weight of the greedy numeral table. Subtractive pairs carry two symbols.
  typedef struct packed {
    logic [VALUE_W-1:0]  weight;
    logic [SYMBOL_W-1:0] first;
    logic [SYMBOL_W-1:0] second;
    logic                pair;
  } entry_t;

  // Table ordered by decreasing weight.
  function automatic entry_t tbl_entry(input logic [TBL_IDX_W-1:0] idx);
    entry_t e;
    unique case (idx)
      4'd0:    e = '{weight: 12'd1000, first: CH_M, second: CH_M, pair: 1'b0};
      4'd1:    e = '{weight: 12'd900,  first: CH_C, second: CH_M, pair: 1'b1};
      4'd2:    e = '{weight: 12'd500,  first: CH_D, second: CH_D, pair: 1'b0};
      4'd3:    e = '{weight: 12'd400,  first: CH_C, second: CH_D, pair: 1'b1};
      4'd4:    e = '{weight: 12'd100,  first: CH_C, second: CH_C, pair: 1'b0};
      4'd5:    e = '{weight: 12'd90,   first: CH_X, second: CH_C, pair: 1'b1};
      4'd6:    e = '{weight: 12'd50,   first: CH_L, second: CH_L, pair: 1'b0};
      4'd7:    e = '{weight: 12'd40,   first: CH_X, second: CH_L, pair: 1'b1};
      4'd8:    e = '{weight: 12'd10,   first: CH_X, second: CH_X, pair: 1'b0};
      4'd9:    e = '{weight: 12'd9,    first: CH_I, second: CH_X, pair: 1'b1};
      4'd10:   e = '{weight: 12'd5,    first: CH_V, second: CH_V, pair: 1'b0};
      4'd11:   e = '{weight: 12'd4,    first: CH_I, second: CH_V, pair: 1'b1};
      default: e = '{weight: 12'd1,    first: CH_I, second: CH_I, pair: 1'b0};
    endcase
    return e;
  endfunction

endpackage

// ----- design/binary_to_roman_numeral_encoder_top.sv -----
// ----------------------------------------------------------------------------
// Binary to Roman numeral encoder
// Converts a 12-bit value to its Roman numeral, one ASCII character per beat.
// ----------------------------------------------------------------------------
// A value is taken when start is high and busy is low; values above 3999 are
// treated as 3999. Each character appears on symbol_o for one cycle with
// valid_o high, and last_o marks the final character; the receiver cannot
// stall, so it must take every beat as it comes. Busy stays high while the
// greedy subtract step produces exactly one character per cycle, and 3888
// gives the longest numeral; a value of zero gives no beat.
module binary_to_roman_numeral_encoder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [b2r_pkg::VALUE_W-1:0]  value_i,
  output logic                         valid_o,
  output logic [b2r_pkg::SYMBOL_W-1:0] symbol_o,
  output logic                         last_o
);

  b2r_pkg::cmd_t cmd;
  b2r_pkg::sts_t sts;

  b2r_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  b2r_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .value_i  (value_i),
    .valid_o  (valid_o),
    .symbol_o (symbol_o),
    .last_o   (last_o)
  );

endmodule

// ----- design/b2r_datapath.sv -----
// ----------------------------------------------------------------------------
// Roman numeral encoder datapath
// Holds the remaining value, picks the largest table weight that fits and
// produces one numeral character per emit command.
// ----------------------------------------------------------------------------
`include "binary_to_roman_numeral_encoder_top_defines.svh"

module b2r_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  b2r_pkg::cmd_t                cmd_i,
  output b2r_pkg::sts_t                sts_o,
  input  logic [b2r_pkg::VALUE_W-1:0]  value_i,
  output logic                         valid_o,
  output logic [b2r_pkg::SYMBOL_W-1:0] symbol_o,
  output logic                         last_o
);

  logic [b2r_pkg::VALUE_W-1:0]   rem_q, rem_d;
  logic                          half_q, half_d;
  logic                          valid_q;
  logic [b2r_pkg::SYMBOL_W-1:0]  symbol_q;
  logic                          last_q;

  logic [b2r_pkg::TBL_IDX_W-1:0] sel;
  b2r_pkg::entry_t               ent;
  logic [b2r_pkg::SYMBOL_W-1:0]  sym;
  logic [b2r_pkg::VALUE_W-1:0]   diff;
  logic                          pair_head;
  logic [b2r_pkg::VALUE_W-1:0]   clamped;

  // Largest weight not above the remainder; the scan runs downward so that the
  // lowest matching index, the largest weight, is kept.
  always_comb begin
    b2r_pkg::entry_t cand;
    sel = b2r_pkg::TBL_IDX_W'(b2r_pkg::TBL_N - 1);
    for (int k = b2r_pkg::TBL_N - 1; k >= 0; k--) begin
      cand = b2r_pkg::tbl_entry(b2r_pkg::TBL_IDX_W'(k));
      if (rem_q >= cand.weight) begin
        sel = b2r_pkg::TBL_IDX_W'(k);
      end
    end
  end

  always_comb begin
    ent       = b2r_pkg::tbl_entry(sel);
    pair_head = ent.pair && !half_q;
    sym       = (ent.pair && half_q) ? ent.second : ent.first;
    diff      = rem_q - ent.weight;
    clamped   = (value_i > b2r_pkg::VALUE_MAX) ? b2r_pkg::VALUE_MAX : value_i;

    sts_o.zero       = (rem_q == '0);
    sts_o.final_char = !pair_head && (diff == '0);

    rem_d  = rem_q;
    half_d = half_q;
    if (cmd_i.load) begin
      rem_d  = clamped;
      half_d = 1'b0;
    end else if (cmd_i.emit) begin
      // The first symbol of a subtractive pair leaves the remainder alone.
      if (pair_head) begin
        half_d = 1'b1;
      end else begin
        rem_d  = diff;
        half_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      half_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      rem_q   <= rem_d;
      half_q  <= half_d;
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      symbol_q <= sym;
      last_q   <= sts_o.final_char;
    end
  end

  assign valid_o  = valid_q;
  assign symbol_o = symbol_q;
  assign last_o   = last_q;

  `B2R_ASSERT(a_rem_in_range, rem_q <= b2r_pkg::VALUE_MAX, "remainder above range")
  `B2R_ASSERT(a_half_on_pair, half_q |-> ent.pair, "pair tail without a pair weight")
  `B2R_ASSERT(a_final_marks_last, cmd_i.emit && sts_o.final_char |=> valid_q && last_q,
              "final character not marked")
  `B2R_ASSERT(a_more_after_inner, valid_q && !last_q |-> rem_q != '0,
              "numeral ended without a last mark")

endmodule

// ----- design/b2r_ctrl.sv -----
// ----------------------------------------------------------------------------
// Roman numeral encoder controller
// Accepts a value, then steps the datapath one character per cycle until the
// final character of the numeral has gone out; a zero value gives no character.
// ----------------------------------------------------------------------------
module b2r_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output b2r_pkg::cmd_t cmd_o,
  input  b2r_pkg::sts_t sts_i
);

  b2r_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= b2r_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.emit = 1'b0;
    busy       = 1'b0;
    unique case (state_q)
      b2r_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = b2r_pkg::ST_RUN;
        end
      end
      b2r_pkg::ST_RUN: begin
        busy = 1'b1;
        // A zero value has no characters at all.
        if (sts_i.zero) begin
          state_d = b2r_pkg::ST_IDLE;
        end else begin
          cmd_o.emit = 1'b1;
          if (sts_i.final_char) begin
            state_d = b2r_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = b2r_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
